@@ src/brms_pkg.sv @@
// Package for the box rule match scorer: cell control struct, FSM states,
// configuration register indexes, opcodes and score level codes. No dependencies.
`default_nettype none
package brms_pkg;

   typedef struct packed {
      logic wr;
      logic rd;
      logic cmp;
      logic first;
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_COUNT,
      ST_SCORE,
      ST_OUT
   } state_type;

   localparam logic       CSR_NUM_RULES  = 1'b0;
   localparam logic       CSR_NUM_LAYERS = 1'b1;
   localparam logic       OP_WRITE       = 1'b0;
   localparam logic       OP_QUERY       = 1'b1;
   localparam logic [2:0] LEVEL_NONE     = 3'd0;
   localparam logic [2:0] LEVEL_LOW      = 3'd1;
   localparam logic [2:0] LEVEL_MID      = 3'd2;
   localparam logic [2:0] LEVEL_HIGH     = 3'd3;
   localparam logic [2:0] LEVEL_FULL     = 3'd4;

endpackage
`default_nettype wire

@@ src/brms_cell.sv @@
// One rule cell: bound memory per layer, match flag and one stage of the
// count shift chain. Depends on brms_pkg.
`default_nettype none
module brms_cell #(
   parameter int MAX_LAYERS = 16,
   parameter int LAW        = 4,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire brms_pkg::cell_ctl_type       ctl,
   input  wire logic                         sel,
   input  wire logic [LAW-1:0]               addr,
   input  wire logic signed [VALUE_BITS-1:0] low,
   input  wire logic signed [VALUE_BITS-1:0] high,
   input  wire logic signed [VALUE_BITS-1:0] query,
   input  wire logic                         shift_in,
   output logic                              shift_out
);
   import brms_pkg::*;

   logic signed [VALUE_BITS-1:0] low_mem  [MAX_LAYERS];
   logic signed [VALUE_BITS-1:0] high_mem [MAX_LAYERS];
   logic signed [VALUE_BITS-1:0] low_rd_ff;
   logic signed [VALUE_BITS-1:0] high_rd_ff;
   logic flag_ff, flag_in;
   logic shift_ff, shift_in_nx;
   logic hit;

   always_ff @(posedge clock) begin
      if (ctl.wr && sel) begin
         low_mem[addr]  <= low;
         high_mem[addr] <= high;
      end
      if (ctl.rd) begin
         low_rd_ff  <= low_mem[addr];
         high_rd_ff <= high_mem[addr];
      end
   end

   assign hit = (low_rd_ff <= query) && (query <= high_rd_ff);

   always_comb begin
      flag_in = flag_ff;
      if (ctl.cmp) begin
         flag_in = ctl.first ? hit : (flag_ff & hit);
      end
      shift_in_nx = shift_ff;
      if (ctl.load) begin
         shift_in_nx = flag_in;
      end else if (ctl.shift) begin
         shift_in_nx = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         flag_ff  <= flag_in;
         shift_ff <= shift_in_nx;
      end
   end

   assign shift_out = shift_ff;

endmodule
`default_nettype wire

@@ src/box_rule_match_score.sv @@
// Top level of the box rule match scorer: control FSM, rule cell chain,
// match counter and score stage. Depends on brms_pkg and brms_cell.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | opcode, indexes, bounds, query value
//   rsp     | out       | rsp_valid/rsp_ready  | match_count, score_level
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A query layer reads the bound memory, then compares in every cell. After the
// last layer the flags shift down the chain into the counter, then the score
// is computed and registered in the result register. Reset clears the flags
// and the FSM state and sets the rule and layer counts to 1 and 2; bounds are
// undefined until written. A stalled result holds req_ready low.
`default_nettype none
module box_rule_match_score #(
   parameter int MAX_RULES  = 64,
   parameter int MAX_LAYERS = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_opcode,
   input  wire logic [5:0]                   req_rule_index,
   input  wire logic [3:0]                   req_layer_index,
   input  wire logic signed [VALUE_BITS-1:0] req_low_bound,
   input  wire logic signed [VALUE_BITS-1:0] req_high_bound,
   input  wire logic signed [VALUE_BITS-1:0] req_query_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [6:0]                        rsp_match_count,
   output logic [2:0]                        rsp_score_level,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [6:0]                   csr_data
);
   import brms_pkg::*;

   localparam int LAW = $clog2(MAX_LAYERS);
   localparam int CW  = $clog2(MAX_RULES + 1);
   localparam int NW  = CW + 4;

   state_type state_ff, state_in;
   cell_ctl_type ctl;
   logic [6:0] num_rules_ff;
   logic [4:0] num_layers_ff;
   logic signed [VALUE_BITS-1:0] query_ff;
   logic first_ff, last_ff;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0] out_count_ff;
   logic [2:0] out_level_ff;
   logic [2:0] level;
   logic [LAW+3:0] layer_ext;
   logic [LAW-1:0] addr;
   logic [7:0] layers_eff;
   logic [10:0] rules_eff;
   logic [MAX_RULES:0] chain;
   logic req_acc, is_query, q_ok, q_last;
   logic [NW-1:0] k_ext, n_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rules_ff  <= 7'd1;
         num_layers_ff <= 5'd2;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_RULES:  num_rules_ff  <= csr_data;
            CSR_NUM_LAYERS: num_layers_ff <= csr_data[4:0];
            default:        num_rules_ff  <= num_rules_ff;
         endcase
      end
   end

   assign layers_eff = (8'(num_layers_ff) > 8'(MAX_LAYERS)) ? 8'(MAX_LAYERS)
                                                            : 8'(num_layers_ff);
   assign rules_eff  = (11'(num_rules_ff) > 11'(MAX_RULES)) ? 11'(MAX_RULES)
                                                            : 11'(num_rules_ff);
   assign layer_ext  = {{LAW{1'b0}}, req_layer_index};
   assign addr       = layer_ext[LAW-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign is_query  = (req_opcode == OP_QUERY);
   assign q_ok      = 8'(req_layer_index) < layers_eff;
   assign q_last    = (8'(req_layer_index) + 8'd1) == layers_eff;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      pos_in    = pos_ff;
      count_in  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!is_query) begin
                  ctl.wr = (32'(layer_ext) < 32'(MAX_LAYERS));
               end else if (q_ok) begin
                  ctl.rd   = 1'b1;
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            ctl.cmp   = 1'b1;
            ctl.first = first_ff;
            ctl.load  = last_ff;
            pos_in    = '0;
            count_in  = '0;
            state_in  = last_ff ? ST_COUNT : ST_IDLE;
         end
         ST_COUNT: begin
            ctl.shift = 1'b1;
            if (chain[0] && (11'(pos_ff) < rules_eff)) begin
               count_in = count_ff + CW'(1);
            end
            pos_in = pos_ff + CW'(1);
            if (32'(pos_ff) == MAX_RULES - 1) begin
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      count_ff <= count_in;
      if (req_acc && is_query) begin
         query_ff <= req_query_value;
         first_ff <= (req_layer_index == 4'd0);
         last_ff  <= q_last;
      end
      if (state_ff == ST_SCORE) begin
         out_count_ff <= (32'(count_ff) > 127) ? 7'd127 : 7'(count_ff);
         out_level_ff <= level;
      end
   end

   assign k_ext = NW'(count_ff);
   assign n_ext = NW'(rules_eff);

   always_comb begin
      if (k_ext == '0 || n_ext == '0) begin
         level = LEVEL_NONE;
      end else if (NW'(10) * k_ext < n_ext) begin
         level = LEVEL_LOW;
      end else if (NW'(4) * k_ext < n_ext) begin
         level = LEVEL_MID;
      end else if (NW'(10) * k_ext < NW'(9) * n_ext) begin
         level = LEVEL_HIGH;
      end else begin
         level = LEVEL_FULL;
      end
   end

   assign chain[MAX_RULES] = 1'b0;

   for (genvar r = 0; r < MAX_RULES; r++) begin : g_cell
      brms_cell #(
         .MAX_LAYERS (MAX_LAYERS),
         .LAW        (LAW),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sel       (32'(req_rule_index) == r),
         .addr      (addr),
         .low       (req_low_bound),
         .high      (req_high_bound),
         .query     (query_ff),
         .shift_in  (chain[r+1]),
         .shift_out (chain[r])
      );
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_match_count = out_count_ff;
   assign rsp_score_level = out_level_ff;

endmodule
`default_nettype wire

@@ src/brms_checker.sv @@
// Port-level checker for the box rule match scorer and its bind to the top
// level. Depends on box_rule_match_score ports only.
`default_nettype none
module brms_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_match_count,
   input wire logic [2:0] rsp_score_level
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count))
      else $error("result dropped or changed while stalled");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_score_level <= 3'd4)
      else $error("score level out of range");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_match_count == 7'd0) == (rsp_score_level == 3'd0)))
      else $error("score level disagrees with match count");

   a_one_txn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

endmodule

bind box_rule_match_score brms_checker u_brms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_count (rsp_match_count),
   .rsp_score_level (rsp_score_level)
);
`default_nettype wire

@@ test/box_rule_match_score_test.sv @@
// Testbench for box_rule_match_score: drives bound writes, query layers and
// register writes, and checks every result against a scoreboard predictor.
// Depends on brms_pkg and the box_rule_match_score RTL.
`timescale 1ns / 100ps
`default_nettype none

module box_rule_match_score_test;
   import brms_pkg::*;

   localparam int NRULES     = 64;
   localparam int NLAYERS    = 16;
   localparam int SETTLE     = NRULES + 16;
   localparam int CYCLE_STOP = 1500000;

   typedef struct packed {
      logic [6:0] match_count;
      logic [2:0] score_level;
   } score_type;

   class match_scoreboard;
      logic signed [31:0] low_tab[NRULES][NLAYERS];
      logic signed [31:0] high_tab[NRULES][NLAYERS];
      bit                 hit[NRULES];
      int unsigned        rules_reg = 1;
      int unsigned        layers_reg = 2;
      score_type          pending[$];
      int                 errors = 0;

      function void set_reg(logic idx, logic [6:0] data);
         if (idx == CSR_NUM_RULES) begin
            rules_reg = 32'(data);
         end else begin
            layers_reg = 32'(data & 7'h1f);
         end
      endfunction

      function void note_item(logic op, logic [5:0] rule, logic [3:0] layer,
                              logic signed [31:0] lo, logic signed [31:0] hi,
                              logic signed [31:0] value);
         int unsigned nl;
         int unsigned nr;
         int unsigned cnt;
         score_type   s;
         nl = (layers_reg > NLAYERS) ? NLAYERS : layers_reg;
         nr = (rules_reg > NRULES) ? NRULES : rules_reg;
         cnt = 0;
         if (op == OP_WRITE) begin
            low_tab[rule][layer] = lo;
            high_tab[rule][layer] = hi;
            return;
         end
         if (int'(layer) >= nl) return;
         for (int r = 0; r < NRULES; r++) begin
            if (layer == 0) begin
               hit[r] = (low_tab[r][layer] <= value) && (value <= high_tab[r][layer]);
            end else begin
               hit[r] = hit[r] && (low_tab[r][layer] <= value)
                        && (value <= high_tab[r][layer]);
            end
         end
         if (int'(layer) != nl - 1) return;
         for (int r = 0; r < nr; r++) begin
            if (hit[r]) cnt++;
         end
         s.match_count = (cnt > 127) ? 7'd127 : cnt[6:0];
         if (cnt == 0 || nr == 0) s.score_level = LEVEL_NONE;
         else if (10 * cnt < nr) s.score_level = LEVEL_LOW;
         else if (4 * cnt < nr) s.score_level = LEVEL_MID;
         else if (10 * cnt < 9 * nr) s.score_level = LEVEL_HIGH;
         else s.score_level = LEVEL_FULL;
         pending.push_back(s);
      endfunction

      function void check(logic [6:0] cnt, logic [2:0] lvl);
         score_type s;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: match_count %0d score_level %0d", cnt, lvl);
            return;
         end
         s = pending.pop_front();
         if (cnt !== s.match_count || lvl !== s.score_level) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: match_count exp %0d got %0d, score_level exp %0d got %0d",
                        s.match_count, cnt, s.score_level, lvl);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_opcode = 0;
   logic [5:0]         req_rule_index = 0;
   logic [3:0]         req_layer_index = 0;
   logic signed [31:0] req_low_bound = 0;
   logic signed [31:0] req_high_bound = 0;
   logic signed [31:0] req_query_value = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [6:0]         rsp_match_count;
   logic [2:0]         rsp_score_level;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic               csr_index = 0;
   logic [6:0]         csr_data = 0;

   match_scoreboard board = new();
   int                 idle_pct = 30;
   int                 hold_count = 0;
   int                 cycles = 0;
   int                 sent = 0;

   box_rule_match_score dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_STOP) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_count > 0) hold_count <= hold_count - 1;
   end

   always @(negedge clock) begin
      rsp_ready = !reset && hold_count == 0 && ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check(rsp_match_count, rsp_score_level);
   end

   task automatic send(logic op, logic [5:0] rule, logic [3:0] layer,
                       logic signed [31:0] lo, logic signed [31:0] hi,
                       logic signed [31:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_opcode = op;
      req_rule_index = rule;
      req_layer_index = layer;
      req_low_bound = lo;
      req_high_bound = hi;
      req_query_value = value;
      do @(posedge clock); while (!req_ready);
      board.note_item(op, rule, layer, lo, hi, value);
      sent++;
   endtask

   task automatic write_reg(logic idx, logic [6:0] data);
      @(negedge clock);
      req_valid = 0;
      csr_valid = 1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_regs(logic [6:0] rules, logic [6:0] layers);
      drain();
      write_reg(CSR_NUM_RULES, rules);
      write_reg(CSR_NUM_LAYERS, layers);
   endtask

   // box radius grows with the rule index so match fractions spread out
   task automatic write_box(int r, int l);
      int rad;
      rad = (r + 1) * 700 + int'($urandom_range(0, 2000));
      if ($urandom_range(0, 19) == 0)
         send(OP_WRITE, 6'(r), 4'(l), 32'sh80000000, 32'sh7fffffff, $urandom);
      else
         send(OP_WRITE, 6'(r), 4'(l), -rad + int'($urandom_range(0, 300)),
              rad - int'($urandom_range(0, 300)), $urandom);
   endtask

   task automatic query(int nl);
      for (int l = 0; l < nl; l++)
         send(OP_QUERY, 6'($urandom), 4'(l), $urandom, $urandom,
              $signed($urandom_range(0, 100000)) - 50000);
   endtask

   task automatic run_phase(int items);
      int nl;
      int pick;
      int stop;
      stop = sent + items;
      while (sent < stop) begin
         nl = (board.layers_reg > NLAYERS) ? NLAYERS : int'(board.layers_reg);
         if (nl == 0) nl = int'($urandom_range(1, NLAYERS));
         pick = int'($urandom_range(0, 99));
         if (pick < 65) query(nl);
         else if (pick < 85) write_box(int'($urandom_range(0, NRULES - 1)),
                                       int'($urandom_range(0, NLAYERS - 1)));
         else if (pick < 92) send(OP_WRITE, 6'($urandom), 4'($urandom), $urandom,
                                  $urandom, $urandom);
         else send(OP_QUERY, 6'($urandom), 4'($urandom), $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      write_reg(CSR_NUM_RULES, 7'd64);
      write_reg(CSR_NUM_LAYERS, 7'd16);
      for (int r = 0; r < NRULES; r++)
         for (int l = 0; l < NLAYERS; l++) write_box(r, l);

      idle_pct = 0;
      send(OP_WRITE, 6'd63, 4'd15, 32'sh80000000, 32'sh7fffffff, 0);
      send(OP_WRITE, 6'd0, 4'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      for (int l = 0; l < NLAYERS; l++) send(OP_QUERY, 6'd0, 4'(l), 0, 0, 0);
      for (int l = 0; l < NLAYERS; l++) send(OP_QUERY, 6'd63, 4'(l), 0, 0, 32'sh80000000);
      send(OP_QUERY, 6'd0, 4'd0, 0, 0, 32'sh7fffffff);
      for (int l = NLAYERS - 1; l > 0; l--) send(OP_QUERY, 6'd0, 4'(l), 0, 0, 1000);
      write_box(0, 0);
      set_regs(7'd1, 7'd2);
      query(2);
      send(OP_QUERY, 6'd0, 4'd9, 0, 0, 0);
      set_regs(7'd0, 7'd1);
      query(1);
      set_regs(7'd127, 7'd0);
      query(4);
      set_regs(7'd100, 7'd20);
      query(16);

      hold_count = 400;
      idle_pct = 30;
      run_phase(24);
      set_regs(7'd64, 7'd16);
      idle_pct = 0;
      run_phase(30);
      idle_pct = 30;
      set_regs(7'd1, 7'd2);
      run_phase(8);
      set_regs(7'd64, 7'd2);
      run_phase(8);
      set_regs(7'd13, 7'd5);
      run_phase(8);
      set_regs(7'd0, 7'd3);
      run_phase(8);
      set_regs(7'd127, 7'd1);
      run_phase(8);
      set_regs(7'd100, 7'd20);
      run_phase(8);
      set_regs(7'd40, 7'd0);
      run_phase(8);
      set_regs(7'd7, 7'd16);
      run_phase(8);
      set_regs(7'd64, 7'd16);
      run_phase(8);

      drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
